/* rtl/core/sipkh_pkg.sv */
// shared types, constants and the sipround function for the keyed hash core
`default_nettype none

package sipkh_pkg;

    localparam int CFG_IDX_W = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ROUNDS = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FINAL_ROUNDS = 4'd3;

    localparam logic [3:0] BLOCK_ROUNDS_RST = 4'd2;
    localparam logic [3:0] FINAL_ROUNDS_RST = 4'd4;
    localparam logic [3:0] FULL_BYTES       = 4'd8;
    localparam logic [4:0] EXTRA_ROUNDS     = 5'd4;

    localparam logic [63:0] INIT_A = 64'h0706050403020100;
    localparam logic [63:0] INIT_B = 64'h0f0e0d0c0b0a0908;
    localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
    localparam logic [63:0] FINAL_MARK = 64'h00000000000000ff;

    localparam logic [63:0] INIT_V0 = INIT_A ^ SIP_C0;
    localparam logic [63:0] INIT_V1 = INIT_B ^ SIP_C1;
    localparam logic [63:0] INIT_V2 = INIT_A ^ SIP_C2;
    localparam logic [63:0] INIT_V3 = INIT_B ^ SIP_C3;

    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } sip_state_t;

    // decoded configuration write
    typedef struct packed {
        logic        key_low_we;
        logic        key_high_we;
        logic        block_we;
        logic        final_we;
        logic [63:0] data;
    } cfg_wr_t;

    // controller to datapath
    typedef struct packed {
        logic start;      // word accepted this cycle
        logic pre_xor;    // v3 ^= word
        logic round;      // one sipround
        logic post_xor;   // v0 ^= word
        logic mark;       // v2 ^= 0xff
        logic load_tail;  // next word is the length-only tail
        logic capture;    // load the hash output register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_full;
        logic in_last;
    } dp_status_t;

    function automatic sip_state_t sip_round(input sip_state_t s);
        logic [63:0] a0;
        logic [63:0] a1;
        logic [63:0] a2;
        logic [63:0] a3;
        sip_state_t  r;
        a2 = s.v2 + s.v3;
        a3 = {s.v3[47:0], s.v3[63:48]} ^ a2;
        a0 = s.v0 + s.v1;
        a1 = {s.v1[50:0], s.v1[63:51]} ^ a0;
        a0 = {a0[31:0], a0[63:32]};
        a2 = a2 + a1;
        a0 = a0 + a3;
        a1 = {a1[46:0], a1[63:47]} ^ a2;
        a3 = {a3[42:0], a3[63:43]} ^ a0;
        a2 = {a2[31:0], a2[63:32]};
        r.v0 = a0;
        r.v1 = a1;
        r.v2 = a2;
        r.v3 = a3;
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/siphash_keyed_hash_core.sv */
// top level of the keyed 64-bit siphash-style hash core
//
//  channel   direction  ports                                          moves
//  input     in         s_valid s_ready s_data_word s_byte_count s_last  message word
//  result    out        m_valid m_ready m_hash_value                   hash word
//  config    in         cfg_valid cfg_ready cfg_index cfg_wdata        register write
//
//  one sipround unit in the datapath runs one round per cycle while nothing stalls; a
//  non-last full word runs block_rounds rounds, the next word is taken in the cycle after;
//  a last word ends with a tail word (length byte over the short bytes, or length only
//  after a full last word) and its tail rounds, then final_rounds + EXTRA_ROUNDS rounds
//  (round counts capped at MAX_ROUNDS); the hash is held in an output register until
//  taken, and only the last finalisation round waits on it; reset is synchronous, no clearing pass
`default_nettype none

module siphash_keyed_hash_core
    import sipkh_pkg::*;
#(
    parameter int MAX_ROUNDS = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]          cfg_wdata,
    // message word channel
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [63:0]          s_data_word,
    input  wire logic [3:0]           s_byte_count,
    input  wire logic                 s_last,
    // hash result channel
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [63:0]               m_hash_value
);

    cfg_wr_t    cfg_wr;
    dp_cmd_t    cmd;
    dp_status_t status;
    logic       cfg_fire;

    // register writes are always taken; an index beyond the list is dropped
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_comb begin
        cfg_wr             = '0;
        cfg_wr.data        = cfg_wdata;
        cfg_wr.key_low_we  = cfg_fire && (cfg_index == REG_KEY_LOW);
        cfg_wr.key_high_we = cfg_fire && (cfg_index == REG_KEY_HIGH);
        cfg_wr.block_we    = cfg_fire && (cfg_index == REG_BLOCK_ROUNDS);
        cfg_wr.final_we    = cfg_fire && (cfg_index == REG_FINAL_ROUNDS);
    end

    // sequencing of rounds and both handshakes
    sipkh_ctrl #(
        .MAX_ROUNDS (MAX_ROUNDS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_wr  (cfg_wr),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // keys, hash state, word and length registers, output register
    sipkh_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr       (cfg_wr),
        .s_data_word  (s_data_word),
        .s_byte_count (s_byte_count),
        .s_last       (s_last),
        .cmd          (cmd),
        .status       (status),
        .m_hash_value (m_hash_value)
    );

endmodule

`default_nettype wire

/* rtl/core/sipkh_dp.sv */
// datapath: key registers, hash state, message word, length and output register
`default_nettype none

module sipkh_dp
    import sipkh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cfg_wr_t     cfg_wr,
    input  wire logic [63:0] s_data_word,
    input  wire logic [3:0]  s_byte_count,
    input  wire logic        s_last,
    input  wire dp_cmd_t     cmd,
    output dp_status_t       status,
    output logic      [63:0] m_hash_value
);

    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;
    sip_state_t  v_reg;
    logic [63:0] word_reg;
    logic [7:0]  length_reg;
    logic        fresh_reg;
    logic [63:0] hash_reg;

    logic [3:0]  count_eff;
    logic [7:0]  length_in;
    logic [7:0]  length_cur;
    logic [63:0] tail_bytes;
    logic [63:0] word_in;
    logic [63:0] word_cur;
    sip_state_t  v_a;
    sip_state_t  v_b;
    sip_state_t  v_c;
    sip_state_t  v_next;

    assign status.in_last = s_last;
    assign status.in_full = !s_last || (s_byte_count >= FULL_BYTES);

    assign count_eff  = status.in_full ? FULL_BYTES : s_byte_count;
    assign length_in  = (fresh_reg ? 8'd0 : length_reg) + {4'd0, count_eff};
    assign length_cur = cmd.start ? length_in : length_reg;

    // bytes above the count read as zero
    always_comb begin
        tail_bytes = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < s_byte_count) begin
                tail_bytes[i*8 +: 8] = s_data_word[i*8 +: 8];
            end
        end
    end

    assign word_in  = status.in_full ? s_data_word : {length_in, tail_bytes[55:0]};
    assign word_cur = cmd.start ? word_in : word_reg;

    always_comb begin
        if (cmd.start && fresh_reg) begin
            v_a.v0 = INIT_V0 ^ key_low_reg;
            v_a.v1 = INIT_V1 ^ key_high_reg;
            v_a.v2 = INIT_V2 ^ key_low_reg;
            v_a.v3 = INIT_V3 ^ key_high_reg;
        end else begin
            v_a = v_reg;
        end
        v_b = v_a;
        if (cmd.pre_xor) begin
            v_b.v3 = v_a.v3 ^ word_cur;
        end
        v_c = cmd.round ? sip_round(v_b) : v_b;
        v_next = v_c;
        if (cmd.post_xor) begin
            v_next.v0 = v_c.v0 ^ word_cur;
        end
        if (cmd.mark) begin
            v_next.v2 = v_c.v2 ^ FINAL_MARK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            fresh_reg    <= 1'b1;
        end else begin
            if (cfg_wr.key_low_we) begin
                key_low_reg <= cfg_wr.data;
            end
            if (cfg_wr.key_high_we) begin
                key_high_reg <= cfg_wr.data;
            end
            if (cmd.capture) begin
                fresh_reg <= 1'b1;
            end else if (cmd.start) begin
                fresh_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        v_reg <= v_next;
        if (cmd.start) begin
            length_reg <= length_in;
        end
        if (cmd.load_tail) begin
            word_reg <= {length_cur, 56'd0};
        end else if (cmd.start) begin
            word_reg <= word_in;
        end
        if (cmd.capture) begin
            hash_reg <= v_next.v0 ^ v_next.v1 ^ v_next.v2 ^ v_next.v3;
        end
    end

    assign m_hash_value = hash_reg;

endmodule

`default_nettype wire

/* rtl/core/sipkh_ctrl.sv */
// controller: round sequencing, round-count registers and both handshakes
`default_nettype none

module sipkh_ctrl
    import sipkh_pkg::*;
#(
    parameter int MAX_ROUNDS = 8
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cfg_wr_t    cfg_wr,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    localparam int CNT_W = $clog2(MAX_ROUNDS + 5);
    localparam logic [4:0] MAX_R = 5'(MAX_ROUNDS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BLOCK,
        ST_TAIL,
        ST_FINAL
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             last_reg, last_next;
    logic             m_valid_reg, m_valid_next;
    logic [3:0]       block_rounds_reg;
    logic [3:0]       final_rounds_reg;

    logic [4:0]       blk_sat;
    logic [4:0]       fin_sat;
    logic [5:0]       fin_total;
    logic             out_busy;

    assign blk_sat   = ({1'b0, block_rounds_reg} > MAX_R) ? MAX_R : {1'b0, block_rounds_reg};
    assign fin_sat   = ({1'b0, final_rounds_reg} > MAX_R) ? MAX_R : {1'b0, final_rounds_reg};
    assign fin_total = {1'b0, fin_sat} + {1'b0, EXTRA_ROUNDS};
    assign out_busy  = m_valid_reg && !m_ready;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start   = 1'b1;
                    cmd.pre_xor = 1'b1;
                    last_next   = status.in_last;
                    if (status.in_full) begin
                        cmd.round = (blk_sat != 5'd0);
                        if (blk_sat <= 5'd1) begin
                            cmd.post_xor = 1'b1;
                            if (status.in_last) begin
                                cmd.load_tail = 1'b1;
                                state_next    = ST_TAIL;
                                cnt_next      = CNT_TWO;
                            end
                        end else begin
                            state_next = ST_BLOCK;
                            cnt_next   = CNT_W'(blk_sat - 5'd1);
                        end
                    end else begin
                        // short last word goes straight to the tail rounds
                        cmd.round  = 1'b1;
                        state_next = ST_TAIL;
                        cnt_next   = CNT_ONE;
                    end
                end
            end
            ST_BLOCK: begin
                cmd.round = 1'b1;
                if (cnt_reg == CNT_ONE) begin
                    cmd.post_xor = 1'b1;
                    if (last_reg) begin
                        cmd.load_tail = 1'b1;
                        state_next    = ST_TAIL;
                        cnt_next      = CNT_TWO;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    cnt_next = cnt_reg - CNT_ONE;
                end
            end
            ST_TAIL: begin
                cmd.round   = 1'b1;
                cmd.pre_xor = (cnt_reg == CNT_TWO);
                if (cnt_reg == CNT_ONE) begin
                    cmd.post_xor = 1'b1;
                    cmd.mark     = 1'b1;
                    state_next   = ST_FINAL;
                    cnt_next     = CNT_W'(fin_total);
                end else begin
                    cnt_next = cnt_reg - CNT_ONE;
                end
            end
            ST_FINAL: begin
                if (cnt_reg == CNT_ONE) begin
                    if (!out_busy) begin
                        cmd.round   = 1'b1;
                        cmd.capture = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end else begin
                    cmd.round = 1'b1;
                    cnt_next  = cnt_reg - CNT_ONE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        m_valid_next = cmd.capture || out_busy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            last_reg         <= 1'b0;
            m_valid_reg      <= 1'b0;
            block_rounds_reg <= BLOCK_ROUNDS_RST;
            final_rounds_reg <= FINAL_ROUNDS_RST;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr.block_we) begin
                block_rounds_reg <= cfg_wr.data[3:0];
            end
            if (cfg_wr.final_we) begin
                final_rounds_reg <= cfg_wr.data[3:0];
            end
        end
    end

`ifndef ASSERT_OFF
    a_capture_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |-> !out_busy)
        else $error("hash captured over an untaken result");

    a_capture_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> m_valid_reg)
        else $error("captured hash not presented");

    a_busy_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (cnt_reg != '0))
        else $error("round counter empty while busy");

    a_tail_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINAL) && $changed(state_reg) |-> $past(cmd.mark))
        else $error("finalisation entered without the final mark");
`endif

endmodule

`default_nettype wire

/* sim/tb_siphash_keyed_hash_core.sv */
// self-checking testbench for the keyed siphash-style hash core
module tb_siphash_keyed_hash_core;
    import sipkh_pkg::*;

    // hash constants kept here so that the checker does not lean on the package values
    localparam logic [63:0] IV_A     = 64'h0706050403020100;
    localparam logic [63:0] IV_B     = 64'h0f0e0d0c0b0a0908;
    localparam logic [63:0] MIX_C0   = 64'h736f6d6570736575;
    localparam logic [63:0] MIX_C1   = 64'h646f72616e646f6d;
    localparam logic [63:0] MIX_C2   = 64'h6c7967656e657261;
    localparam logic [63:0] MIX_C3   = 64'h7465646279746573;
    localparam logic [63:0] END_MARK = 64'h00000000000000ff;
    localparam logic [3:0]  WHOLE    = 4'd8;   // bytes in a full word
    localparam logic [3:0]  TAIL_MIX = 4'd2;   // rounds for the tail word
    localparam logic [3:0]  XTRA_MIX = 4'd4;   // fixed rounds after final_rounds
    localparam int          ROUND_CAP = 8;     // matches the core's MAX_ROUNDS
    // an index past the last register, writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd7;

    localparam int SETTLE_CYCLES = 32;   // longest word is 8 + 2 + 8 + 4 rounds
    localparam int LONG_HOLD     = 300;  // receiver hold-off, enough to back up the input
    localparam int PHASE_WORDS   = 55;   // random words per configuration phase

    typedef struct {
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
        bit          wait_done;   // sender pauses until every hash has come back
    } msg_word_t;

    // clock and reset
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    always #5 aclk = ~aclk;

    // block inputs, all known from time zero
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic [63:0]          s_data_word = '0;
    logic [3:0]           s_byte_count = '0;
    logic                 s_last = 1'b0;
    logic                 m_ready = 1'b0;
    // block outputs
    logic                 cfg_ready;
    logic                 s_ready;
    logic                 m_valid;
    logic [63:0]          m_hash_value;

    siphash_keyed_hash_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_word  (s_data_word),
        .s_byte_count (s_byte_count),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

    // ------------------------------------------------------------------
    // hash predictor: its own copy of the registers and the running state
    // ------------------------------------------------------------------
    logic [63:0] key_lo = '0;
    logic [63:0] key_hi = '0;
    logic [3:0]  blk_rounds = 4'd2;
    logic [3:0]  fin_rounds = 4'd4;
    logic [63:0] hv0 = '0, hv1 = '0, hv2 = '0, hv3 = '0;
    logic [7:0]  msg_len = '0;
    bit          msg_fresh = 1'b1;

    msg_word_t   word_q[$];   // words still to be offered
    logic [63:0] hash_q[$];   // hashes owed by the core, oldest first

    int  mismatches = 0;
    int  words_done = 0;
    int  words_queued = 0;
    int  hashes_seen = 0;
    int  reg_writes = 0;
    int  settings_run = 0;
    bit  no_idle = 1'b0;      // both sides run flat out while set
    int  hold_asks = 0;       // bumped by the stimulus to ask for a long hold-off
    int  hold_seen = 0;
    int  stall_left = 0;
    int  send_gap = 0;
    msg_word_t next_word;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int n);
        return (x << n) | (x >> (64 - n));
    endfunction

    // one sipround on the predictor state
    function automatic void mix_once();
        hv2 = hv2 + hv3;
        hv3 = rotl(hv3, 16) ^ hv2;
        hv0 = hv0 + hv1;
        hv1 = rotl(hv1, 13) ^ hv0;
        hv0 = rotl(hv0, 32);
        hv2 = hv2 + hv1;
        hv0 = hv0 + hv3;
        hv1 = rotl(hv1, 17) ^ hv2;
        hv3 = rotl(hv3, 21) ^ hv0;
        hv2 = rotl(hv2, 32);
    endfunction

    // round counts above the cap saturate, zero runs nothing
    function automatic void mix_rounds(input logic [3:0] n);
        int cnt;
        cnt = (int'(n) > ROUND_CAP) ? ROUND_CAP : int'(n);
        for (int i = 0; i < cnt; i++) mix_once();
    endfunction

    function automatic void fold_word(input logic [63:0] w, input logic [3:0] n);
        hv3 = hv3 ^ w;
        mix_rounds(n);
        hv0 = hv0 ^ w;
    endfunction

    // takes one accepted message word, queues the hash when the message closes
    function automatic void absorb_word(input logic [63:0] data, input logic [3:0] count,
                                        input logic last);
        logic [3:0]  n;
        logic [63:0] tail;
        int          nb;
        if (msg_fresh) begin
            // keys are sampled only at the start of a message
            hv0 = IV_A ^ MIX_C0 ^ key_lo;
            hv1 = IV_B ^ MIX_C1 ^ key_hi;
            hv2 = IV_A ^ MIX_C2 ^ key_lo;
            hv3 = IV_B ^ MIX_C3 ^ key_hi;
            msg_len = '0;
            msg_fresh = 1'b0;
        end
        // oversized counts and every non-last word count as a full word
        n = (count > WHOLE || !last) ? WHOLE : count;
        msg_len = msg_len + 8'(n);
        if (n == WHOLE) begin
            fold_word(data, blk_rounds);
            if (!last) return;
            tail = '0;   // full last word still gets a length-only tail
        end else begin
            nb = int'(n);
            tail = (nb == 0) ? 64'd0 : (data & ({64{1'b1}} >> (64 - 8 * nb)));
        end
        tail = tail | {msg_len, 56'd0};
        fold_word(tail, TAIL_MIX);
        hv2 = hv2 ^ END_MARK;
        mix_rounds(fin_rounds);
        mix_rounds(XTRA_MIX);
        hash_q.push_back(hv0 ^ hv1 ^ hv2 ^ hv3);
        msg_fresh = 1'b1;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
        case (idx)
            REG_KEY_LOW:      key_lo = d;
            REG_KEY_HIGH:     key_hi = d;
            REG_BLOCK_ROUNDS: blk_rounds = d[3:0];
            REG_FINAL_ROUNDS: fin_rounds = d[3:0];
            default: ;   // unmapped index, ignored
        endcase
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // sender: offers queued words, predicts on every accepted word
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_word(s_data_word, s_byte_count, s_last);
                words_done++;
                if (!no_idle && $urandom_range(0, 2) == 0) send_gap = pick_gap();
            end
            if (s_valid && !s_ready) begin
                // word still on offer, payload held
            end else if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (word_q.size() != 0 && !(word_q[0].wait_done && hash_q.size() != 0)) begin
                next_word = word_q.pop_front();
                s_valid      <= 1'b1;
                s_data_word  <= next_word.data;
                s_byte_count <= next_word.count;
                s_last       <= next_word.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random back-pressure plus the long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            stall_left = LONG_HOLD;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // checker: every hash word against the oldest prediction
    // ------------------------------------------------------------------
    logic [63:0] want_hash;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (hash_q.size() == 0) begin
                $error("hash_value: expected none, got %h", m_hash_value);
                mismatches++;
            end else begin
                want_hash = hash_q.pop_front();
                hashes_seen++;
                if (m_hash_value !== want_hash) begin
                    $error("hash_value: expected %h, got %h", want_hash, m_hash_value);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic push_word(input logic [63:0] data, input logic [3:0] count,
                             input logic last, input bit wait_done = 1'b0);
        msg_word_t w;
        w.data = data;
        w.count = count;
        w.last = last;
        w.wait_done = wait_done;
        word_q.push_back(w);
        words_queued++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // register write, predictor updated on the accepting edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_reg(idx, d);
        reg_writes++;
    endtask

    // core idle: nothing left to offer, nothing owed, then room for a word with no result
    // sampled mid-cycle so that the edge's queue and handshake updates have all landed
    task automatic settle();
        do @(negedge aclk); while (word_q.size() != 0 || s_valid || hash_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_rounds(input logic [3:0] blk, input logic [3:0] fin);
        write_reg(REG_BLOCK_ROUNDS, {60'd0, blk});
        write_reg(REG_FINAL_ROUNDS, {60'd0, fin});
        settings_run++;
    endtask

    // well-formed message with random content: full words then a tail word
    task automatic push_random_message(input bit pause_first);
        int nfull;
        int r;
        logic [3:0] cnt;
        r = $urandom_range(0, 99);
        if (r < 60) nfull = $urandom_range(0, 3);
        else if (r < 94) nfull = $urandom_range(4, 10);
        else nfull = $urandom_range(30, 36);   // can run the length byte past 255
        for (int i = 0; i < nfull; i++) begin
            // a few non-last words carry a short or oversized count
            cnt = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : WHOLE;
            push_word(rand64(), cnt, 1'b0, pause_first && i == 0);
        end
        cnt = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
        push_word(rand64(), cnt, 1'b1, pause_first && nfull == 0);
    endtask

    initial begin
        int start_words;
        int msgs;
        logic [3:0] blk;
        logic [3:0] fin;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset settings: empty message with junk data, tails, full last word
        push_word(rand64(), 4'd0, 1'b1);
        push_word('1, 4'd7, 1'b1);
        push_word('1, WHOLE, 1'b1);
        push_word('0, WHOLE, 1'b0);
        push_word('1, 4'd1, 1'b1);
        // oversized counts on last words
        push_word('1, 4'd15, 1'b1);
        push_word('1, 4'd9, 1'b1);
        // short, empty and oversized non-last words are absorbed whole
        push_word('1, 4'd3, 1'b0);
        push_word('1, 4'd5, 1'b1);
        push_word('1, 4'd0, 1'b0);
        push_word('1, 4'd15, 1'b0);
        push_word('0, WHOLE, 1'b1);
        settle();

        // all-ones keys, most block rounds, zero final_rounds
        write_reg(REG_KEY_LOW, '1);
        write_reg(REG_KEY_HIGH, '1);
        set_rounds(4'd8, 4'd0);
        push_word('1, WHOLE, 1'b0);
        push_word('0, 4'd4, 1'b1);
        // key change mid message only counts from the next message
        push_word(rand64(), WHOLE, 1'b0);
        settle();
        write_reg(REG_KEY_LOW, rand64());
        set_rounds(4'd1, 4'd8);
        push_word(rand64(), 4'd6, 1'b1);
        push_word(rand64(), WHOLE, 1'b1);
        settle();

        // counts above the cap saturate, spare index changes nothing
        write_reg(REG_KEY_HIGH, '0);
        write_reg(REG_SPARE, '1);
        set_rounds(4'd15, 4'd15);
        push_word(rand64(), WHOLE, 1'b0);
        push_word(rand64(), 4'd2, 1'b1);
        settle();
        // zero block rounds
        set_rounds(4'd0, 4'd8);
        push_word(rand64(), WHOLE, 1'b0);
        push_word(rand64(), WHOLE, 1'b1);
        settle();

        // random phases, each with fresh keys and round counts
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_KEY_LOW, rand64());
            write_reg(REG_KEY_HIGH, rand64());
            write_reg(4'(REG_FINAL_ROUNDS + 1 + $urandom_range(0, 11)), rand64());
            blk = (ph == 0) ? 4'd1 : (ph == 1) ? 4'd8 : 4'($urandom_range(1, 8));
            fin = (ph == 0) ? 4'd8 : (ph == 1) ? 4'd0 : 4'($urandom_range(0, 8));
            set_rounds(blk, fin);
            no_idle = (ph == 2);
            // long receiver hold-off while the sender keeps offering
            if (ph == 3) hold_asks++;
            start_words = words_queued;
            msgs = 0;
            while (words_queued - start_words < PHASE_WORDS) begin
                // sender waits for every hash before a couple of messages
                push_random_message(ph == 4 && (msgs == 2 || msgs == 5));
                msgs++;
            end
            // leave a message open across the next settings change
            if (ph == 1) begin
                push_word(rand64(), WHOLE, 1'b0);
                push_word(rand64(), WHOLE, 1'b0);
            end
            settle();
        end
        no_idle = 1'b0;

        $display("covered %0d message words and %0d hashes over %0d round settings",
                 words_done, hashes_seen, settings_run);
        $display("%0d register writes, including saturating, zero and unmapped cases",
                 reg_writes);
        if (mismatches == 0 && hash_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
